>>> rtl/slc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slc_pkg: shared types and constants of the shifting array list
// Widths, request and status codes, controller states and the structs that
// travel between the controller and the row of storage cells.
// ---------------------------------------------------------------------------
package slc_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int WORD_W   = 32;
  localparam int POS_W    = 7;
  localparam int FOUND_W  = 6;
  localparam int ECNT_W   = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_REMOVE = 3'd4,
    REQ_FIND   = 3'd5,
    REQ_READ   = 3'd6
  } req_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_RANGE    = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_SCAN,
    FSM_DONE
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [IDX_W-1:0]          from;
    logic                      load_en;
    logic [IDX_W-1:0]          load_at;
    logic signed [WORD_W-1:0]  load_word;
  } cell_ctl_t;

  typedef struct packed {
    logic                      is_empty;
    logic [ECNT_W-1:0]         entry_count;
    logic [FOUND_W-1:0]        found_at;
    logic signed [WORD_W-1:0]  word_out;
    status_t                   status;
  } result_t;

endpackage

>>> rtl/slc_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slc_cell: one storage cell of the list
// Holds one entry. Each cycle it keeps its word, takes the word of its lower
// or upper neighbor, or loads the broadcast word when its index is addressed.
// ---------------------------------------------------------------------------
module slc_cell (
  input  logic                              clk,
  input  slc_pkg::cell_ctl_t                ctl,
  input  logic [slc_pkg::IDX_W-1:0]         idx,
  input  logic signed [slc_pkg::WORD_W-1:0] left,
  input  logic signed [slc_pkg::WORD_W-1:0] right,
  output logic signed [slc_pkg::WORD_W-1:0] q
);

  logic signed [slc_pkg::WORD_W-1:0] q_next;

  always_comb begin
    q_next = q;
    if (ctl.load_en && (idx == ctl.load_at)) begin
      q_next = ctl.load_word;
    end else if ((ctl.op == slc_pkg::CELL_SHIFT_UP) && (idx > ctl.from)) begin
      q_next = left;
    end else if ((ctl.op == slc_pkg::CELL_SHIFT_DOWN) && (idx >= ctl.from)) begin
      q_next = right;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> rtl/slc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slc_ctrl: request sequencer of the shifting array list
// Decodes a request, drives the cell row, rotates the list through the row
// for remove, find and read, and holds the result beat in an output register.
// ---------------------------------------------------------------------------
module slc_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  slc_pkg::req_t                     req_in,
  input  logic [slc_pkg::POS_W-1:0]         pos_in,
  input  logic signed [slc_pkg::WORD_W-1:0] word_in,
  input  logic signed [slc_pkg::WORD_W-1:0] head,
  output slc_pkg::cell_ctl_t                ctl,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output slc_pkg::result_t                  res_out
);

  localparam int IW = slc_pkg::IDX_W;
  localparam int CW = slc_pkg::CNT_W;
  localparam int PW = slc_pkg::CMP_W;

  slc_pkg::state_t state, state_next;

  slc_pkg::req_t                     req_r;
  logic [slc_pkg::POS_W-1:0]         pos_r;
  logic signed [slc_pkg::WORD_W-1:0] word_r;

  logic [CW-1:0]                     count, count_next;
  logic [CW-1:0]                     cnt0;
  logic [CW-1:0]                     len, len_after;
  logic [IW-1:0]                     step;
  logic                              found, found_now;
  logic [IW-1:0]                     at, at_now;
  logic signed [slc_pkg::WORD_W-1:0] rd, rd_now;

  logic             finish, scan_start, out_free, keep, last_step, head_match;
  logic             full, empty, pos_ok_ins, pos_ok_idx;
  slc_pkg::result_t res_now, res_hold;

  assign out_free   = !m_tvalid || m_tready;
  assign full       = (count == CW'(slc_pkg::DEPTH));
  assign empty      = (count == '0);
  assign pos_ok_ins = (PW'(pos_r) <= PW'(count));
  assign pos_ok_idx = (PW'(pos_r) < PW'(count));
  assign head_match = (head == word_r);
  assign keep       = !((req_r == slc_pkg::REQ_REMOVE) && head_match);
  assign len_after  = keep ? len : len - CW'(1);
  assign last_step  = ((CW'(step) + CW'(1)) == cnt0);
  assign found_now  = found || head_match;
  assign at_now     = found ? at : step;
  assign rd_now     = (PW'(step) == PW'(pos_r)) ? head : rd;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      slc_pkg::FSM_IDLE: begin
        if (s_tvalid) state_next = slc_pkg::FSM_EXEC;
      end
      slc_pkg::FSM_EXEC: begin
        if (finish) state_next = out_free ? slc_pkg::FSM_IDLE : slc_pkg::FSM_DONE;
        else        state_next = slc_pkg::FSM_SCAN;
      end
      slc_pkg::FSM_SCAN: begin
        if (finish) state_next = out_free ? slc_pkg::FSM_IDLE : slc_pkg::FSM_DONE;
      end
      slc_pkg::FSM_DONE: begin
        if (out_free) state_next = slc_pkg::FSM_IDLE;
      end
      default: state_next = slc_pkg::FSM_IDLE;
    endcase
  end

  // Outputs: cell commands, completion and the result of the current request.
  always_comb begin
    s_tready          = (state == slc_pkg::FSM_IDLE);
    ctl.op            = slc_pkg::CELL_HOLD;
    ctl.from          = '0;
    ctl.load_en       = 1'b0;
    ctl.load_at       = '0;
    ctl.load_word     = word_r;
    finish            = 1'b0;
    scan_start        = 1'b0;
    count_next        = count;
    res_now.status    = slc_pkg::STAT_OK;
    res_now.word_out  = '0;
    res_now.found_at  = '0;
    case (state)
      slc_pkg::FSM_EXEC: begin
        case (req_r)
          slc_pkg::REQ_PUSH: begin
            finish = 1'b1;
            if (full) begin
              res_now.status = slc_pkg::STAT_FULL;
            end else begin
              ctl.load_en = 1'b1;
              ctl.load_at = IW'(count);
              count_next  = count + CW'(1);
            end
          end
          slc_pkg::REQ_POP: begin
            finish = 1'b1;
            if (empty) res_now.status = slc_pkg::STAT_EMPTY;
            else       count_next = count - CW'(1);
          end
          slc_pkg::REQ_INSERT: begin
            finish = 1'b1;
            if (!pos_ok_ins) begin
              res_now.status = slc_pkg::STAT_RANGE;
            end else if (full) begin
              res_now.status = slc_pkg::STAT_FULL;
            end else begin
              ctl.op      = slc_pkg::CELL_SHIFT_UP;
              ctl.from    = IW'(pos_r);
              ctl.load_en = 1'b1;
              ctl.load_at = IW'(pos_r);
              count_next  = count + CW'(1);
            end
          end
          slc_pkg::REQ_DELETE: begin
            finish = 1'b1;
            if (!pos_ok_idx) begin
              res_now.status = slc_pkg::STAT_RANGE;
            end else begin
              ctl.op     = slc_pkg::CELL_SHIFT_DOWN;
              ctl.from   = IW'(pos_r);
              count_next = count - CW'(1);
            end
          end
          slc_pkg::REQ_REMOVE: begin
            if (empty) finish = 1'b1;
            else       scan_start = 1'b1;
          end
          slc_pkg::REQ_FIND: begin
            if (empty) begin
              finish         = 1'b1;
              res_now.status = slc_pkg::STAT_NOTFOUND;
            end else begin
              scan_start = 1'b1;
            end
          end
          slc_pkg::REQ_READ: begin
            if (!pos_ok_idx) begin
              finish         = 1'b1;
              res_now.status = slc_pkg::STAT_RANGE;
            end else begin
              scan_start = 1'b1;
            end
          end
          default: finish = 1'b1;
        endcase
      end
      slc_pkg::FSM_SCAN: begin
        // The head leaves the row and, unless removed, rejoins at the tail.
        ctl.op        = slc_pkg::CELL_SHIFT_DOWN;
        ctl.load_en   = keep;
        ctl.load_at   = IW'(len - CW'(1));
        ctl.load_word = head;
        if (last_step) begin
          finish     = 1'b1;
          count_next = len_after;
          if (req_r == slc_pkg::REQ_FIND) begin
            res_now.status   = found_now ? slc_pkg::STAT_OK : slc_pkg::STAT_NOTFOUND;
            res_now.found_at = found_now ? slc_pkg::FOUND_W'(at_now) : '0;
          end
          if (req_r == slc_pkg::REQ_READ) res_now.word_out = rd_now;
        end
      end
      default: ;
    endcase
    res_now.entry_count = slc_pkg::ECNT_W'(count_next);
    res_now.is_empty    = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= slc_pkg::FSM_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((finish || (state == slc_pkg::FSM_DONE)) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_r  <= req_in;
      pos_r  <= pos_in;
      word_r <= word_in;
    end
    if (scan_start) begin
      step  <= '0;
      cnt0  <= count;
      len   <= count;
      found <= 1'b0;
      at    <= '0;
      rd    <= '0;
    end else if (state == slc_pkg::FSM_SCAN) begin
      step  <= step + IW'(1);
      len   <= len_after;
      found <= found_now;
      at    <= at_now;
      rd    <= rd_now;
    end
    if (finish) begin
      if (out_free) res_out <= res_now;
      else          res_hold <= res_now;
    end else if ((state == slc_pkg::FSM_DONE) && out_free) begin
      res_out <= res_hold;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(slc_pkg::DEPTH))
    else $error("entry count above capacity");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (state == slc_pkg::FSM_SCAN) |-> ((len <= cnt0) && (CW'(step) < cnt0)))
    else $error("rotation ran past the list length");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (finish && out_free) |=> (m_tvalid && (state == slc_pkg::FSM_IDLE)))
    else $error("finished request did not reach the output register");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == slc_pkg::FSM_DONE) |-> m_tvalid)
    else $error("result held back while output register is free");

endmodule

>>> rtl/shifting_array_list_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shifting_array_list_unit: ordered list of signed words in a row of cells
// Keeps up to DEPTH entries with push, pop, insert, delete, remove, find
// and read requests, answering each request with one status beat.
// ---------------------------------------------------------------------------
// Usage:
//   A request beat enters on the s_ side (tuser carries the request code,
//   tdata the index and the word). Each request gives exactly one result
//   beat on the m_ side with status, read word, found index, entry count
//   and an empty flag.
//   Push, pop, insert, delete and out-of-range or empty-list requests are
//   accepted in the idle state and complete in the execute state, where the
//   cells shift or load in parallel as needed. Remove, find and read rotate
//   the whole list once through the cell row, one entry per cycle, in the
//   scan state. A finished result is registered onto m_tvalid once the
//   output register is free, and is held until then.
//   A new request is accepted while a finished result waits for m_tready;
//   the one after it then waits until the output register drains.
//   Reset empties the list; cell contents are not cleared and are never
//   visible beyond the entry count.
// ---------------------------------------------------------------------------
module shifting_array_list_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[6:0], word_in[38:7], zero[39]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // status[2:0], word_out[34:3], found_at[40:35],
                                 // entry_count[47:41], is_empty[48], zero[55:49]
);

  logic signed [slc_pkg::WORD_W-1:0] cell_q [slc_pkg::DEPTH];
  slc_pkg::cell_ctl_t                ctl;
  slc_pkg::result_t                  res;

  slc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_in   (slc_pkg::req_t'(s_tuser)),
    .pos_in   (s_tdata[6:0]),
    .word_in  (s_tdata[38:7]),
    .head     (cell_q[0]),
    .ctl      (ctl),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res_out  (res)
  );

  for (genvar i = 0; i < slc_pkg::DEPTH; i++) begin : g_cell
    logic signed [slc_pkg::WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_q[i];
    end else begin : g_mid_lo
      assign left_w = cell_q[i-1];
    end
    if (i == slc_pkg::DEPTH - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_mid_hi
      assign right_w = cell_q[i+1];
    end
    slc_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (slc_pkg::IDX_W'(i)),
      .left  (left_w),
      .right (right_w),
      .q     (cell_q[i])
    );
  end

  assign m_tdata = {7'd0, res.is_empty, res.entry_count, res.found_at,
                    res.word_out, res.status};

endmodule
